### hdl/rbi_pkg.sv
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared widths, register indexes and defaults of the ray/box intersect block.
// ----------------------------------------------------------------------------
package rbi_pkg;

    // Field widths.
    localparam int COORD_W   = 32;
    localparam int HALF_W    = 31;
    localparam int DIST_W    = 31;
    localparam int FACE_W    = 3;
    localparam int CFG_IDX_W = 3;

    // Magnitude of a plane offset from the origin, before the fraction shift.
    localparam int NMAG_W = 33;

    // Default number of fraction bits.
    localparam int FRAC_BITS_DEF = 16;

    localparam int NUM_AXES  = 3;
    localparam int NUM_FACES = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Y   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_Z   = 3'd5;

endpackage

### hdl/rbi_ray_if.sv
// ----------------------------------------------------------------------------
// rbi_ray_if
// Ray channel: origin and direction in signed fixed point.
// ----------------------------------------------------------------------------
interface rbi_ray_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [rbi_pkg::COORD_W-1:0]   origin_x;
    logic signed [rbi_pkg::COORD_W-1:0]   origin_y;
    logic signed [rbi_pkg::COORD_W-1:0]   origin_z;
    logic signed [rbi_pkg::COORD_W-1:0]   dir_x;
    logic signed [rbi_pkg::COORD_W-1:0]   dir_y;
    logic signed [rbi_pkg::COORD_W-1:0]   dir_z;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    output ready);
endinterface

### hdl/rbi_res_if.sv
// ----------------------------------------------------------------------------
// rbi_res_if
// Result channel: hit flag, nearest distance and face code.
// ----------------------------------------------------------------------------
interface rbi_res_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [rbi_pkg::DIST_W-1:0]    distance;
    logic [rbi_pkg::FACE_W-1:0]    face;

    modport source (output valid, hit, distance, face, input ready);
    modport sink   (input valid, hit, distance, face, output ready);
endinterface

### hdl/rbi_cfg_if.sv
// ----------------------------------------------------------------------------
// rbi_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rbi_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rbi_pkg::CFG_IDX_W-1:0]   index;
    logic [rbi_pkg::COORD_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hdl/rbi_div.sv
// ----------------------------------------------------------------------------
// rbi_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbi_div #(
    parameter int NW = 49,
    parameter int DW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic          in_ok,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic          out_ok
);

    logic [DW-1:0] rem_reg [NW];
    logic [NW-1:0] num_reg [NW];
    logic [NW-1:0] quo_reg [NW];
    logic [DW-1:0] den_reg [NW];
    logic          ok_reg  [NW];
    logic          vld_reg [NW];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [NW-1:0] num_in;
        logic [NW-1:0] quo_in;
        logic          ok_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          take;
        logic [DW-1:0] rem_next;
        logic [NW-1:0] quo_next;

        // The first stage starts from the operands with an empty remainder.
        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign den_in = in_den;
            assign num_in = in_num;
            assign quo_in = '0;
            assign ok_in  = in_ok;
            assign vld_in = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign ok_in  = ok_reg[k-1];
            assign vld_in = vld_reg[k-1];
        end

        // Bring down the next numerator bit and subtract where it fits.
        assign trial    = {rem_in, num_in[NW-1]};
        assign take     = trial >= {1'b0, den_in};
        assign rem_next = take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
        assign quo_next = {quo_in[NW-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                num_reg[k] <= {num_in[NW-2:0], 1'b0};
                quo_reg[k] <= quo_next;
                ok_reg[k]  <= ok_in;
            end
        end
    end

    assign out_valid = vld_reg[NW-1];
    assign out_quo   = quo_reg[NW-1];
    assign out_ok    = ok_reg[NW-1];

endmodule

### hdl/ray_box_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_intersect
// Tests one ray per cycle, while the result is not stalled, against an axis-aligned box held in registers.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  cfg      in         index (3 bits), data (32 bits)
//  ray      in         origin_x/y/z, dir_x/y/z (signed fixed point)
//  res      out        hit, distance (31 bits), face (3 bits)
//
//  One ray enters every cycle while the result is not stalled.
//  A ray passes through the six face dividers, one quotient bit per stage,
//  plus four stages of setup and inside tests and three of face selection.
//  Reset clears all valid bits and loads the box registers with their
//  defaults. A stalled result holds the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
module ray_box_intersect #(
    parameter int FRAC_BITS = rbi_pkg::FRAC_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rbi_cfg_if.sink    cfg,
    rbi_ray_if.sink    ray,
    rbi_res_if.source  res
);

    localparam int CW     = rbi_pkg::COORD_W;
    localparam int HW     = rbi_pkg::HALF_W;
    localparam int FW     = rbi_pkg::FACE_W;
    localparam int DSW    = rbi_pkg::DIST_W;
    localparam int NA     = rbi_pkg::NUM_AXES;
    localparam int NF     = rbi_pkg::NUM_FACES;
    localparam int MW     = rbi_pkg::NMAG_W;
    localparam int AW     = CW + 1;
    localparam int NUM_W  = MW + 1;
    localparam int PA_W   = AW + CW;
    localparam int PN_W   = NUM_W + CW;
    localparam int LIM_W  = HW + CW;
    localparam int SUM_W  = PN_W + 1;
    localparam int QW     = MW + FRAC_BITS;

    // Box registers.
    logic signed [CW-1:0] cen_reg  [NA];
    logic        [HW-1:0] half_reg [NA];

    logic adv;

    // Ray fields as per-axis arrays.
    logic signed [CW-1:0] org [NA];
    logic signed [CW-1:0] dir [NA];

    assign org[0] = ray.origin_x;
    assign org[1] = ray.origin_y;
    assign org[2] = ray.origin_z;
    assign dir[0] = ray.dir_x;
    assign dir[1] = ray.dir_y;
    assign dir[2] = ray.dir_z;

    // The pipeline moves whenever the output register is free or drained.
    assign adv       = !res.valid || res.ready;
    assign ray.ready = adv;
    assign cfg.ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                cen_reg[i]  <= '0;
                half_reg[i] <= HW'(1) << FRAC_BITS;
            end
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                rbi_pkg::REG_CENTER_X: cen_reg[0]  <= cfg.data;
                rbi_pkg::REG_CENTER_Y: cen_reg[1]  <= cfg.data;
                rbi_pkg::REG_CENTER_Z: cen_reg[2]  <= cfg.data;
                rbi_pkg::REG_HALF_X:   half_reg[0] <= cfg.data[HW-1:0];
                rbi_pkg::REG_HALF_Y:   half_reg[1] <= cfg.data[HW-1:0];
                rbi_pkg::REG_HALF_Z:   half_reg[2] <= cfg.data[HW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: offsets from the box center, plane offsets, magnitudes.
    // ------------------------------------------------------------------
    logic signed [AW-1:0]    s1_a_next    [NA];
    logic        [CW-1:0]    s1_dmag_next [NA];
    logic signed [NUM_W-1:0] s1_num_next  [NF];
    logic        [MW-1:0]    s1_nmag_next [NF];
    logic                    s1_pos_next  [NF];

    logic signed [AW-1:0]    s1_a_reg    [NA];
    logic signed [CW-1:0]    s1_d_reg    [NA];
    logic        [CW-1:0]    s1_dmag_reg [NA];
    logic signed [NUM_W-1:0] s1_num_reg  [NF];
    logic        [MW-1:0]    s1_nmag_reg [NF];
    logic                    s1_pos_reg  [NF];
    logic                    s1_vld_reg;

    always_comb
    begin
        logic signed [NUM_W-1:0] hext;
        logic signed [NUM_W-1:0] aext;
        int ax;
        for (int i = 0; i < NA; i++)
        begin
            s1_a_next[i]    = {org[i][CW-1], org[i]} - {cen_reg[i][CW-1], cen_reg[i]};
            s1_dmag_next[i] = dir[i][CW-1] ? CW'(-dir[i]) : dir[i];
        end
        for (int f = 0; f < NF; f++)
        begin
            ax   = f >> 1;
            hext = {3'b000, half_reg[ax]};
            aext = {s1_a_next[ax][AW-1], s1_a_next[ax]};
            // Even faces sit at +half, odd faces at -half.
            if ((f & 1) == 0)
                s1_num_next[f] = hext - aext;
            else
                s1_num_next[f] = NUM_W'(0) - hext - aext;
            s1_nmag_next[f] = s1_num_next[f][NUM_W-1] ? MW'(-s1_num_next[f])
                                                      : s1_num_next[f][MW-1:0];
            // The ray parameter can only be positive when both signs agree.
            s1_pos_next[f] = (dir[ax] != '0) && (s1_num_next[f] != '0) &&
                             (s1_num_next[f][NUM_W-1] == dir[ax][CW-1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_a_reg    <= s1_a_next;
            s1_d_reg    <= dir;
            s1_dmag_reg <= s1_dmag_next;
            s1_num_reg  <= s1_num_next;
            s1_nmag_reg <= s1_nmag_next;
            s1_pos_reg  <= s1_pos_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross products for the two inside tests of each face.
    // ------------------------------------------------------------------
    logic signed [PA_W-1:0]  s2_pa_next  [NF];
    logic signed [PN_W-1:0]  s2_pna_next [NF];
    logic signed [PA_W-1:0]  s2_pb_next  [NF];
    logic signed [PN_W-1:0]  s2_pnb_next [NF];
    logic        [LIM_W-1:0] s2_la_next  [NF];
    logic        [LIM_W-1:0] s2_lb_next  [NF];

    logic signed [PA_W-1:0]  s2_pa_reg   [NF];
    logic signed [PN_W-1:0]  s2_pna_reg  [NF];
    logic signed [PA_W-1:0]  s2_pb_reg   [NF];
    logic signed [PN_W-1:0]  s2_pnb_reg  [NF];
    logic        [LIM_W-1:0] s2_la_reg   [NF];
    logic        [LIM_W-1:0] s2_lb_reg   [NF];
    logic        [CW-1:0]    s2_dmag_reg [NA];
    logic        [MW-1:0]    s2_nmag_reg [NF];
    logic                    s2_pos_reg  [NF];
    logic                    s2_vld_reg;

    always_comb
    begin
        int ax;
        int oa;
        int ob;
        for (int f = 0; f < NF; f++)
        begin
            ax = f >> 1;
            oa = (ax == 0) ? 1 : 0;
            ob = (ax == 2) ? 1 : 2;
            s2_pa_next[f]  = s1_a_reg[oa] * s1_d_reg[ax];
            s2_pna_next[f] = s1_num_reg[f] * s1_d_reg[oa];
            s2_pb_next[f]  = s1_a_reg[ob] * s1_d_reg[ax];
            s2_pnb_next[f] = s1_num_reg[f] * s1_d_reg[ob];
            s2_la_next[f]  = half_reg[oa] * s1_dmag_reg[ax];
            s2_lb_next[f]  = half_reg[ob] * s1_dmag_reg[ax];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_pa_reg   <= s2_pa_next;
            s2_pna_reg  <= s2_pna_next;
            s2_pb_reg   <= s2_pb_next;
            s2_pnb_reg  <= s2_pnb_next;
            s2_la_reg   <= s2_la_next;
            s2_lb_reg   <= s2_lb_next;
            s2_dmag_reg <= s1_dmag_reg;
            s2_nmag_reg <= s1_nmag_reg;
            s2_pos_reg  <= s1_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scaled coordinates of the crossing point on the plane.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] s3_ca_next [NF];
    logic signed [SUM_W-1:0] s3_cb_next [NF];

    logic signed [SUM_W-1:0] s3_ca_reg   [NF];
    logic signed [SUM_W-1:0] s3_cb_reg   [NF];
    logic        [LIM_W-1:0] s3_la_reg   [NF];
    logic        [LIM_W-1:0] s3_lb_reg   [NF];
    logic        [CW-1:0]    s3_dmag_reg [NA];
    logic        [MW-1:0]    s3_nmag_reg [NF];
    logic                    s3_pos_reg  [NF];
    logic                    s3_vld_reg;

    always_comb
    begin
        for (int f = 0; f < NF; f++)
        begin
            s3_ca_next[f] = SUM_W'(s2_pa_reg[f]) + SUM_W'(s2_pna_reg[f]);
            s3_cb_next[f] = SUM_W'(s2_pb_reg[f]) + SUM_W'(s2_pnb_reg[f]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_ca_reg   <= s3_ca_next;
            s3_cb_reg   <= s3_cb_next;
            s3_la_reg   <= s2_la_reg;
            s3_lb_reg   <= s2_lb_reg;
            s3_dmag_reg <= s2_dmag_reg;
            s3_nmag_reg <= s2_nmag_reg;
            s3_pos_reg  <= s2_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: strict inside tests against the scaled half extents.
    // ------------------------------------------------------------------
    logic                 s4_ok_next  [NF];
    logic                 s4_ok_reg   [NF];
    logic [CW-1:0]        s4_dmag_reg [NA];
    logic [MW-1:0]        s4_nmag_reg [NF];
    logic                 s4_vld_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] la;
        logic signed [SUM_W-1:0] lb;
        logic in_a;
        logic in_b;
        for (int f = 0; f < NF; f++)
        begin
            la   = $signed({{(SUM_W-LIM_W){1'b0}}, s3_la_reg[f]});
            lb   = $signed({{(SUM_W-LIM_W){1'b0}}, s3_lb_reg[f]});
            in_a = (s3_ca_reg[f] < la) && (s3_ca_reg[f] > -la);
            in_b = (s3_cb_reg[f] < lb) && (s3_cb_reg[f] > -lb);
            s4_ok_next[f] = s3_pos_reg[f] && in_a && in_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_ok_reg   <= s4_ok_next;
            s4_dmag_reg <= s3_dmag_reg;
            s4_nmag_reg <= s3_nmag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ray parameter of each face plane through its own divider.
    // ------------------------------------------------------------------
    logic [QW-1:0] dq   [NF];
    logic          dok  [NF];
    logic [NF-1:0] dvld;

    for (genvar f = 0; f < NF; f++) begin : g_div
        rbi_div #(
            .NW (QW),
            .DW (CW)
        ) u_div (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (s4_vld_reg),
            .in_num    ({s4_nmag_reg[f], {FRAC_BITS{1'b0}}}),
            .in_den    (s4_dmag_reg[f >> 1]),
            .in_ok     (s4_ok_reg[f]),
            .out_valid (dvld[f]),
            .out_quo   (dq[f]),
            .out_ok    (dok[f])
        );
    end

    // ------------------------------------------------------------------
    // Selection tree: the earlier face wins a tie at every level.
    // ------------------------------------------------------------------
    logic          ta_v_next  [NA];
    logic [QW-1:0] ta_s_next  [NA];
    logic [FW-1:0] ta_f_next  [NA];

    logic          ta_v_reg   [NA];
    logic [QW-1:0] ta_s_reg   [NA];
    logic [FW-1:0] ta_f_reg   [NA];
    logic          ta_vld_reg;

    always_comb
    begin
        logic vl;
        logic vr;
        logic tr;
        for (int p = 0; p < NA; p++)
        begin
            vl = dok[2*p]   && (dq[2*p]   != '0);
            vr = dok[2*p+1] && (dq[2*p+1] != '0);
            tr = vr && (!vl || (dq[2*p+1] < dq[2*p]));
            ta_v_next[p] = vl || vr;
            ta_s_next[p] = tr ? dq[2*p+1] : dq[2*p];
            ta_f_next[p] = tr ? FW'(2*p+1) : FW'(2*p);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ta_v_reg <= ta_v_next;
            ta_s_reg <= ta_s_next;
            ta_f_reg <= ta_f_next;
        end
    end

    // Combine the x and y pairs, carry the z pair along.
    logic          tb_v_next;
    logic [QW-1:0] tb_s_next;
    logic [FW-1:0] tb_f_next;

    logic          tb_v_reg;
    logic [QW-1:0] tb_s_reg;
    logic [FW-1:0] tb_f_reg;
    logic          tb_zv_reg;
    logic [QW-1:0] tb_zs_reg;
    logic [FW-1:0] tb_zf_reg;
    logic          tb_vld_reg;

    always_comb
    begin
        logic tr;
        tr = ta_v_reg[1] && (!ta_v_reg[0] || (ta_s_reg[1] < ta_s_reg[0]));
        tb_v_next = ta_v_reg[0] || ta_v_reg[1];
        tb_s_next = tr ? ta_s_reg[1] : ta_s_reg[0];
        tb_f_next = tr ? ta_f_reg[1] : ta_f_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tb_v_reg  <= tb_v_next;
            tb_s_reg  <= tb_s_next;
            tb_f_reg  <= tb_f_next;
            tb_zv_reg <= ta_v_reg[2];
            tb_zs_reg <= ta_s_reg[2];
            tb_zf_reg <= ta_f_reg[2];
        end
    end

    // Final pick, saturation and the output register.
    logic           hit_next;
    logic [QW-1:0]  best_s;
    logic [DSW-1:0] dist_next;
    logic [FW-1:0]  face_next;
    logic           hit_reg;
    logic [DSW-1:0] dist_reg;
    logic [FW-1:0]  face_reg;
    logic           res_valid_reg;

    always_comb
    begin
        logic tr;
        tr       = tb_zv_reg && (!tb_v_reg || (tb_zs_reg < tb_s_reg));
        hit_next = tb_v_reg || tb_zv_reg;
        best_s   = tr ? tb_zs_reg : tb_s_reg;
        if (!hit_next)
        begin
            dist_next = '0;
            face_next = '0;
        end
        else
        begin
            dist_next = (best_s[QW-1:DSW] != '0) ? '1 : best_s[DSW-1:0];
            face_next = tr ? tb_zf_reg : tb_f_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg  <= hit_next;
            dist_reg <= dist_next;
            face_reg <= face_next;
        end
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            s4_vld_reg    <= 1'b0;
            ta_vld_reg    <= 1'b0;
            tb_vld_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_vld_reg    <= ray.valid;
            s2_vld_reg    <= s1_vld_reg;
            s3_vld_reg    <= s2_vld_reg;
            s4_vld_reg    <= s3_vld_reg;
            ta_vld_reg    <= &dvld;
            tb_vld_reg    <= ta_vld_reg;
            res_valid_reg <= tb_vld_reg;
        end
    end

    assign res.valid    = res_valid_reg;
    assign res.hit      = hit_reg;
    assign res.distance = dist_reg;
    assign res.face     = face_reg;

    // A miss reports zero distance and face zero.
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.hit |-> (res.distance == '0) && (res.face == '0))
        else $error("miss result carries nonzero distance or face");

    // A hit is only taken at a strictly positive distance.
    a_hit_positive: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.hit |-> (res.distance != '0))
        else $error("hit reported at zero distance");

    // While the output stalls, the pipeline front holds its contents.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |=> $stable(s1_vld_reg) && $stable(s4_vld_reg))
        else $error("pipeline moved during a stall");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Regression for the ray/box intersect block. Rays are queued by a stimulus
// process, sent by a clocked driver with random gaps, and every result is
// compared against a local model of the slab test computed at transfer time.
// The box registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int     FRAC     = rbi_pkg::FRAC_BITS_DEF;
    localparam longint ONE      = longint'(1) <<< FRAC;
    localparam longint DIST_TOP = 64'h7FFF_FFFF;
    localparam int     DRAIN    = FRAC + 50;

    typedef enum logic [rbi_pkg::FACE_W-1:0] {
        FACE_POS_X = 3'd0, FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2, FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4, FACE_NEG_Z = 3'd5
    } face_t;

    typedef struct {
        logic signed [rbi_pkg::COORD_W-1:0] org [3];
        logic signed [rbi_pkg::COORD_W-1:0] dir [3];
    } ray_t;

    typedef struct {
        logic                       hit;
        logic [rbi_pkg::DIST_W-1:0] distance;
        logic [rbi_pkg::FACE_W-1:0] face;
    } hit_t;

    logic clk;
    logic rst_n;

    rbi_cfg_if cfg_bus ();
    rbi_ray_if ray_bus ();
    rbi_res_if res_bus ();

    ray_box_intersect DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_bus),
        .ray   (ray_bus),
        .res   (res_bus)
    );

    // Local copy of the box registers.
    longint box_center [3];
    longint box_half   [3];

    ray_t   ray_q [$];
    hit_t   hit_q [$];
    ray_t   ray_cur;
    int     tx_gap;
    int     rx_gap;
    int     rx_hold;
    bit     idle_on;
    int     errors;

    always #5 clk = ~clk;

    // Gap length: mostly short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(3, 1);
        else if (r < 98)
            return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Strict inside test on the exact rational: |adj*d + num*dv| < half*|d|.
    function automatic bit in_slab(longint adj, longint d, longint num, longint dv,
                                   longint half);
        logic signed [127:0] wa, wd, wn, wv, wh, acc, lim;
        wa  = adj;
        wd  = d;
        wn  = num;
        wv  = dv;
        wh  = half;
        acc = wa * wd + wn * wv;
        if (acc < 0)
            acc = -acc;
        lim = wh * ((wd < 0) ? -wd : wd);
        return acc < lim;
    endfunction

    // Nearest face hit by a ray against the current box.
    function automatic hit_t nearest_face(ray_t r);
        longint rel [3];
        longint dv  [3];
        longint num, s, best;
        int     ax, o1, o2;
        bit     found;
        face_t  fc;
        hit_t   h;
        found = 0;
        best  = 0;
        fc    = FACE_POS_X;
        for (int i = 0; i < 3; i++)
        begin
            rel[i] = longint'(r.org[i]) - box_center[i];
            dv[i]  = longint'(r.dir[i]);
        end
        // Faces in order +x, -x, +y, -y, +z, -z; earlier face wins a tie.
        for (int f = 0; f < rbi_pkg::NUM_FACES; f++)
        begin
            ax = f / 2;
            o1 = (ax + 1) % 3;
            o2 = (ax + 2) % 3;
            if (dv[ax] == 0)
                continue;
            num = ((f % 2 == 0) ? box_half[ax] : -box_half[ax]) - rel[ax];
            s   = (num * ONE) / dv[ax];
            if (s <= 0)
                continue;
            if (found && s >= best)
                continue;
            if (!in_slab(rel[o1], dv[ax], num, dv[o1], box_half[o1]))
                continue;
            if (!in_slab(rel[o2], dv[ax], num, dv[o2], box_half[o2]))
                continue;
            found = 1;
            best  = s;
            fc    = face_t'(f);
        end
        h.hit      = found;
        h.distance = found ? ((best > DIST_TOP) ? DIST_TOP[rbi_pkg::DIST_W-1:0]
                                                : best[rbi_pkg::DIST_W-1:0])
                           : '0;
        h.face     = found ? fc : FACE_POS_X;
        return h;
    endfunction

    // Ray driver.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            ray_bus.valid <= 1'b0;
        end
        else
        begin
            if (ray_bus.valid && ray_bus.ready)
                hit_q.push_back(nearest_face(ray_cur));
            if (ray_bus.valid && !ray_bus.ready)
            begin
                // Hold the offered ray until it transfers.
            end
            else if (tx_gap > 0)
            begin
                tx_gap--;
                ray_bus.valid <= 1'b0;
            end
            else if (ray_q.size() > 0)
            begin
                ray_cur = ray_q.pop_front();
                ray_bus.origin_x <= ray_cur.org[0];
                ray_bus.origin_y <= ray_cur.org[1];
                ray_bus.origin_z <= ray_cur.org[2];
                ray_bus.dir_x    <= ray_cur.dir[0];
                ray_bus.dir_y    <= ray_cur.dir[1];
                ray_bus.dir_z    <= ray_cur.dir[2];
                ray_bus.valid    <= 1'b1;
                if (idle_on && $urandom_range(5) == 0)
                    tx_gap = gap_len();
            end
            else
            begin
                ray_bus.valid <= 1'b0;
            end
        end
    end

    // Result monitor and checker.
    always @(posedge clk)
    begin
        hit_t exp_hit;
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (hit_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Unexpected result transfer: hit %0b distance %0d face %0d",
                                 res_bus.hit, res_bus.distance, res_bus.face);
                end
                else
                begin
                    exp_hit = hit_q.pop_front();
                    if (res_bus.hit !== exp_hit.hit || res_bus.distance !== exp_hit.distance
                        || res_bus.face !== exp_hit.face)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Mismatch: expected hit %0b distance %0d face %0d, %s",
                                     exp_hit.hit, exp_hit.distance, exp_hit.face,
                                     $sformatf("got hit %0b distance %0d face %0d",
                                               res_bus.hit, res_bus.distance,
                                               res_bus.face));
                    end
                end
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                res_bus.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(7) == 0)
                    rx_gap = gap_len();
            end
        end
    end

    // Uniform value in [-m, m].
    function automatic longint rand_span(longint m);
        longint unsigned r;
        if (m <= 0)
            return 0;
        r = {$urandom, $urandom};
        return longint'(r % longint'(2 * m + 1)) - m;
    endfunction

    function automatic logic signed [rbi_pkg::COORD_W-1:0] rand_word();
        return $urandom;
    endfunction

    task automatic add_ray(longint ox, longint oy, longint oz,
                           longint dx, longint dy, longint dz);
        ray_t r;
        r.org[0] = ox[rbi_pkg::COORD_W-1:0];
        r.org[1] = oy[rbi_pkg::COORD_W-1:0];
        r.org[2] = oz[rbi_pkg::COORD_W-1:0];
        r.dir[0] = dx[rbi_pkg::COORD_W-1:0];
        r.dir[1] = dy[rbi_pkg::COORD_W-1:0];
        r.dir[2] = dz[rbi_pkg::COORD_W-1:0];
        ray_q.push_back(r);
    endtask

    // One random ray; most are aimed from around the box at a point inside it.
    task automatic add_random_ray();
        longint org [3];
        longint dir [3];
        longint reach;
        int     mode;
        int     k;
        mode = $urandom_range(9);
        k    = $urandom_range(4);
        for (int i = 0; i < 3; i++)
        begin
            reach  = 4 * box_half[i] + 2 * ONE;
            org[i] = box_center[i] + rand_span(reach);
            dir[i] = (box_center[i] + rand_span(box_half[i]) - org[i]) >>> k;
            if (mode == 7)
            begin
                org[i] = longint'(rand_word());
                dir[i] = longint'(rand_word());
            end
            else if (mode == 8 && $urandom_range(2) == 0)
            begin
                dir[i] = 0;
            end
            else if (mode == 9)
            begin
                org[i] = $urandom_range(1) ? 64'sh7FFF_FFFF - $urandom_range(3)
                                           : -64'sh8000_0000 + $urandom_range(3);
                dir[i] = $urandom_range(1) ? longint'(rand_word()) : rand_span(4);
            end
        end
        add_ray(org[0], org[1], org[2], dir[0], dir[1], dir[2]);
    endtask

    task automatic write_reg(logic [rbi_pkg::CFG_IDX_W-1:0] idx,
                             logic [rbi_pkg::COORD_W-1:0] value);
        @(posedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        unique case (idx)
            rbi_pkg::REG_CENTER_X: box_center[0] = longint'(signed'(value));
            rbi_pkg::REG_CENTER_Y: box_center[1] = longint'(signed'(value));
            rbi_pkg::REG_CENTER_Z: box_center[2] = longint'(signed'(value));
            rbi_pkg::REG_HALF_X:   box_half[0]   = longint'(value[rbi_pkg::HALF_W-1:0]);
            rbi_pkg::REG_HALF_Y:   box_half[1]   = longint'(value[rbi_pkg::HALF_W-1:0]);
            rbi_pkg::REG_HALF_Z:   box_half[2]   = longint'(value[rbi_pkg::HALF_W-1:0]);
            default: ;
        endcase
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_box(longint cx, longint cy, longint cz,
                             longint hx, longint hy, longint hz);
        logic [rbi_pkg::COORD_W-1:0] top;
        // The bit above the half-extent field is ignored; toggle it anyway.
        top = {1'($urandom_range(1)), {(rbi_pkg::COORD_W-1){1'b0}}};
        write_reg(rbi_pkg::REG_CENTER_X, cx[rbi_pkg::COORD_W-1:0]);
        write_reg(rbi_pkg::REG_CENTER_Y, cy[rbi_pkg::COORD_W-1:0]);
        write_reg(rbi_pkg::REG_CENTER_Z, cz[rbi_pkg::COORD_W-1:0]);
        write_reg(rbi_pkg::REG_HALF_X, top | hx[rbi_pkg::COORD_W-1:0]);
        write_reg(rbi_pkg::REG_HALF_Y, top | hy[rbi_pkg::COORD_W-1:0]);
        write_reg(rbi_pkg::REG_HALF_Z, top | hz[rbi_pkg::COORD_W-1:0]);
    endtask

    // Wait until every queued ray has transferred and every result is back.
    task automatic drain();
        while (ray_q.size() > 0 || ray_bus.valid)
            @(posedge clk);
        while (hit_q.size() > 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
            add_random_ray();
        drain();
    endtask

    // Stimulus.
    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        errors           = 0;
        tx_gap           = 0;
        rx_gap           = 0;
        rx_hold          = 0;
        idle_on          = 1'b1;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = rbi_pkg::REG_CENTER_X;
        cfg_bus.data     = '0;
        ray_bus.valid    = 1'b0;
        ray_bus.origin_x = '0;
        ray_bus.origin_y = '0;
        ray_bus.origin_z = '0;
        ray_bus.dir_x    = '0;
        ray_bus.dir_y    = '0;
        ray_bus.dir_z    = '0;
        res_bus.ready    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            box_center[i] = 0;
            box_half[i]   = ONE;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rays against the unit box left by reset.
        add_ray(-3 * ONE, 0, 0, ONE, 0, 0);
        add_ray(3 * ONE, 0, 0, -ONE, 0, 0);
        add_ray(0, -3 * ONE, 0, 0, ONE, 0);
        add_ray(0, 3 * ONE, 0, 0, -ONE, 0);
        add_ray(0, 0, -3 * ONE, 0, 0, ONE);
        add_ray(0, 0, 3 * ONE, 0, 0, -ONE);
        // Origin inside the box: only the face ahead is taken.
        add_ray(0, 0, 0, ONE, 0, 0);
        add_ray(ONE / 4, -ONE / 3, ONE / 5, -ONE, ONE / 2, ONE / 7);
        // All directions zero, parallel miss, ray pointing away.
        add_ray(-3 * ONE, 0, 0, 0, 0, 0);
        add_ray(-3 * ONE, 2 * ONE, 0, ONE, 0, 0);
        add_ray(3 * ONE, 0, 0, ONE, 0, 0);
        // Through an edge and a corner: strict inside test rejects both.
        add_ray(-3 * ONE, -3 * ONE, 0, ONE, ONE, 0);
        add_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE);
        // Near face whose quantized distance is zero.
        add_ray(-ONE - 1, 0, 0, 64'sh7FFF_FFFF, 0, 0);
        // Far plane with a tiny step: distance saturates.
        add_ray(-32767 * ONE, 0, 0, 1, 0, 0);
        add_ray(0, 32000 * ONE, 0, 0, -3, 0);
        // Field extremes.
        add_ray(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        add_ray(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF,
                -64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        add_ray(-64'sh8000_0000, 0, 0, 64'sh7FFF_FFFF, 0, 0);
        add_ray(-2 * ONE, 0, 0, -64'sh8000_0000, -1, -1);
        add_ray(-2 * ONE, ONE / 2, -ONE / 2, 1, 0, 0);
        add_ray(-1, -1, -1, -1, -1, -1);
        drain();
        random_phase(130);

        // Offset box; the receiver holds off while rays keep coming.
        write_box(5 * ONE, -7 * ONE, 2 * ONE, ONE / 2, 3 * ONE, ONE / 8);
        rx_hold = 400;
        random_phase(130);

        // Random box with no idling on either side.
        idle_on = 1'b0;
        write_box(rand_span(50 * ONE), rand_span(50 * ONE), rand_span(50 * ONE),
                  $urandom_range(8 * ONE, 1), $urandom_range(8 * ONE, 1),
                  $urandom_range(8 * ONE, 1));
        random_phase(130);
        idle_on = 1'b1;

        // Flat box: a zero half-extent on one axis.
        write_box(0, ONE, -ONE, 2 * ONE, 0, 2 * ONE);
        random_phase(110);

        // Largest half-extents and most negative centre.
        write_box(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000,
                  64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        random_phase(110);

        // Most positive centre with tiny half-extents.
        write_box(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 1, 2, 3);
        random_phase(110);

        // Two more random boxes with wide ranges.
        for (int p = 0; p < 2; p++)
        begin
            write_box(longint'(rand_word()), longint'(rand_word()), longint'(rand_word()),
                      $urandom_range(64'h7FFF_FFFF), $urandom_range(64 * ONE),
                      $urandom_range(64 * ONE));
            random_phase(150);
        end

        if (errors == 0)
            $display("ray_box_intersect regression: pass");
        else
            $display("ray_box_intersect regression: fail");
        $finish;
    end

    // Run limit.
    initial
    begin
        #5ms;
        $display("ray_box_intersect regression: fail");
        $finish;
    end

endmodule
